[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFMP_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfmp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFMP_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfmp check failed");

`endif

[src/bfmp_pkg.sv]
`timescale 1ns / 1ps

package bfmp_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  localparam int unsigned MAX_FIELD_BITS   = 32;

  localparam int unsigned LEN_W     = 13;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned VAL_IDX_W = $clog2(VAL_W);
  localparam int unsigned WID_W     = 6;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned HEADROOM_BYTES = 4;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned TUSER_W    = 3;

  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(4096);

  typedef enum logic [1:0] {
    CMD_BEGIN_WR = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_BEGIN_RD = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic wr_merge;
    logic wr_byte;
    logic rd_step;
    logic fin;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic cap_ok;
    logic wr_bad_width;
    logic rd_bad_width;
    logic bp_zero;
    logic wr_last;
    logic rd_end;
  } dp_sts_t;

endpackage

[src/bfmp_ram.sv]
`timescale 1ns / 1ps

module bfmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/bfmp_ctrl.sv]
`timescale 1ns / 1ps

module bfmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bfmp_pkg::dp_ctl_t ctl,
  input  bfmp_pkg::dp_sts_t sts
);

  import bfmp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_WR_MERGE = 6'b000100,
    S_WR_BYTE  = 6'b001000,
    S_RD       = 6'b010000,
    S_FIN      = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    ctl          = '0;
    ctl.load     = (state_r == S_IDLE) && in_valid;
    ctl.decode   = (state_r == S_DECODE);
    ctl.wr_merge = (state_r == S_WR_MERGE);
    ctl.wr_byte  = (state_r == S_WR_BYTE);
    ctl.rd_step  = (state_r == S_RD);
    ctl.fin      = fin_go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_WRITE: begin
            if (!sts.cap_ok || sts.wr_bad_width) state_nxt = S_FIN;
            else if (sts.bp_zero)                state_nxt = S_WR_BYTE;
            else                                 state_nxt = S_WR_MERGE;
          end
          CMD_READ: begin
            state_nxt = sts.rd_bad_width ? S_FIN : S_RD;
          end
          CMD_BEGIN_WR, CMD_BEGIN_RD: state_nxt = S_FIN;
          default: state_nxt = S_FIN;
        endcase
      end
      S_WR_MERGE: begin
        state_nxt = sts.wr_last ? S_FIN : S_WR_BYTE;
      end
      S_WR_BYTE: begin
        if (sts.wr_last) state_nxt = S_FIN;
      end
      S_RD: begin
        if (sts.rd_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register frees when taken, refills on fin
  assign out_valid_nxt = fin_go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/bfmp_dp.sv]
`timescale 1ns / 1ps

module bfmp_dp #(
  parameter int unsigned BUFFER_BYTES = bfmp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfmp_pkg::dp_ctl_t             ctl,
  output bfmp_pkg::dp_sts_t             sts,
  input  bfmp_pkg::cmd_t                in_command,
  input  logic [bfmp_pkg::VAL_W-1:0]    in_value,
  input  logic [bfmp_pkg::WID_W-1:0]    in_width,
  input  logic                          in_is_signed,
  input  logic                          cfg_wr_en,
  input  logic [bfmp_pkg::LEN_W-1:0]    cfg_wr_data,
  output logic [bfmp_pkg::VAL_W-1:0]    out_read_value,
  output logic                          out_bad_read,
  output logic                          out_overflowed,
  output logic                          out_bad_width,
  output logic [bfmp_pkg::CNT_W-1:0]    out_range_warnings,
  output logic [bfmp_pkg::LEN_W-1:0]    out_used_bytes
);

  import bfmp_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_BYTES);

  function automatic logic [AW-1:0] addr_before(input logic [LEN_W-1:0] pos);
    logic [AW-1:0] a;
    if (pos == '0) a = AW'(BUFFER_BYTES - 1);
    else           a = AW'(pos - LEN_W'(1));
    return a;
  endfunction

  function automatic logic [7:0] low_mask(input logic [3:0] n);
    return 8'((9'd1 << n) - 9'd1);
  endfunction

  function automatic logic [VAL_W-1:0] field_mask(input logic [WID_W-1:0] n);
    return VAL_W'(((VAL_W+1)'(1) << n) - (VAL_W+1)'(1));
  endfunction

  // request latch
  cmd_t             cmd_r;
  logic [VAL_W-1:0] val_r;
  logic [WID_W-1:0] w_r;
  logic             sg_r;

  // architectural state
  logic [LEN_W-1:0] cap_r, cap_nxt;
  logic [LEN_W-1:0] wl_r, wl_nxt;
  logic [LEN_W-1:0] rp_r, rp_nxt;
  logic [2:0]       bp_r, bp_nxt;
  logic             ovf_r, ovf_nxt;
  logic             badrd_r, badrd_nxt;
  logic [CNT_W-1:0] warn_r, warn_nxt;

  // per-request work registers
  logic [VAL_W-1:0] bits_r, bits_nxt;
  logic [WID_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [WID_W-1:0] got_r, got_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  logic             bw_r, bw_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [2:0]       pend_bp_r, pend_bp_nxt;
  logic [3:0]       pend_take_r, pend_take_nxt;
  logic [WID_W-1:0] pend_got_r, pend_got_nxt;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [LEN_W-1:0] cap_eff;
  logic             cap_ok, wr_bad_w, rd_bad_w, oor;
  logic             oor_u, oor_s;
  logic [VAL_W-1:0] sh_s;
  logic [3:0]       bp_room, wr_take, rd_take;
  logic             wr_last;
  logic [WID_W-1:0] rd_left;
  logic             rd_need, rd_bad;
  logic [AW-1:0]    rd_addr;
  logic [VAL_W-1:0] acc_merge, rd_final;

  bfmp_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign cap_eff = (32'(cap_r) < BUFFER_BYTES) ? cap_r : LEN_W'(BUFFER_BYTES);
  assign cap_ok  = ({1'b0, wl_r} + (LEN_W+1)'(HEADROOM_BYTES)) <= {1'b0, cap_eff};

  assign wr_bad_w = (w_r == '0) || (w_r > WID_W'(MAX_FIELD_BITS)) ||
                    (sg_r && (w_r > WID_W'(VAL_W - 1)));
  assign rd_bad_w = (w_r > WID_W'(MAX_FIELD_BITS));

  // range: unsigned needs zero bits above the field, signed needs a pure sign run
  assign oor_u = (w_r < WID_W'(VAL_W)) && ((val_r >> w_r) != '0);
  assign sh_s  = VAL_W'($signed(val_r) >>> (w_r - WID_W'(1)));
  assign oor_s = (sh_s != '0) && (sh_s != '1);
  assign oor   = sg_r ? oor_s : oor_u;

  assign bp_room = 4'd8 - {1'b0, bp_r};
  assign wr_take = (rem_r < {2'b00, bp_room}) ? rem_r[3:0] : bp_room;
  assign wr_last = (rem_r <= {2'b00, wr_take});

  assign rd_left = w_r - got_r;
  assign rd_take = (rd_left < {2'b00, bp_room}) ? rd_left[3:0] : bp_room;
  assign rd_need = (got_r < w_r);
  assign rd_bad  = (bp_r == 3'd0) && (rp_r >= wl_r);
  assign rd_addr = (bp_r == 3'd0) ? AW'(rp_r) : addr_before(rp_r);

  // byte returned for the chunk requested last cycle
  assign acc_merge = acc_r | (pend_v_r ?
    (VAL_W'((ram_rdata >> pend_bp_r) & low_mask(pend_take_r)) << pend_got_r) : '0);

  always_comb begin
    rd_final = acc_merge;
    if (sg_r && (w_r != '0) && (w_r < WID_W'(VAL_W)) &&
        acc_merge[VAL_IDX_W'(w_r - WID_W'(1))]) begin
      rd_final = acc_merge | ~field_mask(w_r);
    end
  end

  always_comb begin
    sts              = '0;
    sts.cmd          = cmd_r;
    sts.cap_ok       = cap_ok;
    sts.wr_bad_width = wr_bad_w;
    sts.rd_bad_width = rd_bad_w;
    sts.bp_zero      = (bp_r == 3'd0);
    sts.wr_last      = wr_last;
    sts.rd_end       = !rd_need || rd_bad;
  end

  always_comb begin
    cap_nxt       = cap_r;
    wl_nxt        = wl_r;
    rp_nxt        = rp_r;
    bp_nxt        = bp_r;
    ovf_nxt       = ovf_r;
    badrd_nxt     = badrd_r;
    warn_nxt      = warn_r;
    bits_nxt      = bits_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    got_nxt       = got_r;
    rv_nxt        = rv_r;
    bw_nxt        = bw_r;
    pend_v_nxt    = 1'b0;
    pend_bp_nxt   = pend_bp_r;
    pend_take_nxt = pend_take_r;
    pend_got_nxt  = pend_got_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(wl_r);
    ram_wdata     = bits_r[7:0] & low_mask(wr_take);
    ram_raddr     = addr_before(wl_r);

    if (cfg_wr_en) cap_nxt = cfg_wr_data;

    if (ctl.decode) begin
      rv_nxt = '0;
      bw_nxt = 1'b0;
      case (cmd_r)
        CMD_BEGIN_WR: begin
          ovf_nxt = 1'b0;
          wl_nxt  = '0;
          bp_nxt  = '0;
        end
        CMD_BEGIN_RD: begin
          bp_nxt    = '0;
          rp_nxt    = '0;
          badrd_nxt = 1'b0;
        end
        CMD_WRITE: begin
          if (!cap_ok) begin
            ovf_nxt = 1'b1;
          end else if (wr_bad_w) begin
            bw_nxt = 1'b1;
          end else begin
            if (oor) warn_nxt = warn_r + CNT_W'(1);
            bits_nxt = val_r;
            rem_nxt  = w_r;
          end
        end
        CMD_READ: begin
          if (rd_bad_w) begin
            bw_nxt = 1'b1;
          end else begin
            acc_nxt = '0;
            got_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    // partial byte: OR new bits over the byte read during decode
    if (ctl.wr_merge) begin
      ram_we    = 1'b1;
      ram_waddr = addr_before(wl_r);
      ram_wdata = ram_rdata | 8'((bits_r[7:0] & low_mask(wr_take)) << bp_r);
      bits_nxt  = bits_r >> wr_take;
      rem_nxt   = rem_r - WID_W'(wr_take);
      bp_nxt    = 3'({1'b0, bp_r} + wr_take);
    end

    if (ctl.wr_byte) begin
      ram_we   = 1'b1;
      wl_nxt   = wl_r + LEN_W'(1);
      bits_nxt = bits_r >> wr_take;
      rem_nxt  = rem_r - WID_W'(wr_take);
      bp_nxt   = 3'({1'b0, bp_r} + wr_take);
    end

    if (ctl.rd_step) begin
      acc_nxt   = acc_merge;
      ram_raddr = rd_addr;
      if (rd_need) begin
        if (rd_bad) begin
          badrd_nxt = 1'b1;
          rv_nxt    = '1;
        end else begin
          if (bp_r == 3'd0) rp_nxt = rp_r + LEN_W'(1);
          pend_v_nxt    = 1'b1;
          pend_bp_nxt   = bp_r;
          pend_take_nxt = rd_take;
          pend_got_nxt  = got_r;
          bp_nxt        = 3'({1'b0, bp_r} + rd_take);
          got_nxt       = got_r + WID_W'(rd_take);
        end
      end else begin
        rv_nxt = rd_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      wl_r     <= '0;
      rp_r     <= '0;
      bp_r     <= '0;
      ovf_r    <= 1'b0;
      badrd_r  <= 1'b0;
      warn_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      cap_r    <= cap_nxt;
      wl_r     <= wl_nxt;
      rp_r     <= rp_nxt;
      bp_r     <= bp_nxt;
      ovf_r    <= ovf_nxt;
      badrd_r  <= badrd_nxt;
      warn_r   <= warn_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_command;
      val_r <= in_value;
      w_r   <= in_width;
      sg_r  <= in_is_signed;
    end
    bits_r      <= bits_nxt;
    rem_r       <= rem_nxt;
    acc_r       <= acc_nxt;
    got_r       <= got_nxt;
    rv_r        <= rv_nxt;
    bw_r        <= bw_nxt;
    pend_bp_r   <= pend_bp_nxt;
    pend_take_r <= pend_take_nxt;
    pend_got_r  <= pend_got_nxt;
    if (ctl.fin) begin
      out_read_value     <= rv_r;
      out_bad_read       <= badrd_r;
      out_overflowed     <= ovf_r;
      out_bad_width      <= bw_r;
      out_range_warnings <= warn_r;
      out_used_bytes     <= wl_r;
    end
  end

endmodule

[src/bit_field_message_packer.sv]
// Path, accept to result valid: begin, refused and bad-width requests go from decode to the result.
// A write then touches each byte in turn (one byte-RAM write per cycle, the partly
// filled byte is read during decode). A read fetches one byte per step, then a closing step.
// One request at a time; the next is taken the cycle after the result is registered,
// and the final state waits while the previous result has not been taken.
// Reset: synchronous, active low; clears lengths, flags and counters, byte store undefined.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bit_field_message_packer #(
  parameter int unsigned BUFFER_BYTES = bfmp_pkg::BUFFER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] value, [37:32] width, [39:38] zero
  input  logic [bfmp_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] command, [2] is_signed
  input  logic [bfmp_pkg::TUSER_W-1:0]       in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] read_value, [63:32] range_warnings, [76:64] used_bytes, [79:77] zero
  output logic [bfmp_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] bad_read, [1] overflowed, [2] bad_width
  output logic [bfmp_pkg::TUSER_W-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [bfmp_pkg::LEN_W-1:0]         cfg_wr_data
);

  import bfmp_pkg::*;

  dp_ctl_t          ctl;
  dp_sts_t          sts;
  logic [VAL_W-1:0] out_rv;
  logic             out_badrd, out_ovf, out_bw;
  logic [CNT_W-1:0] out_warn;
  logic [LEN_W-1:0] out_used;

  bfmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ctl       (ctl),
    .sts       (sts)
  );

  bfmp_dp #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_command         (cmd_t'(in_tuser[1:0])),
    .in_value           (in_tdata[VAL_W-1:0]),
    .in_width           (in_tdata[VAL_W+WID_W-1:VAL_W]),
    .in_is_signed       (in_tuser[2]),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_read_value     (out_rv),
    .out_bad_read       (out_badrd),
    .out_overflowed     (out_ovf),
    .out_bad_width      (out_bw),
    .out_range_warnings (out_warn),
    .out_used_bytes     (out_used)
  );

  assign out_tdata = {(OUT_DATA_W - LEN_W - CNT_W - VAL_W)'(0), out_used, out_warn, out_rv};
  assign out_tuser = {out_bw, out_ovf, out_badrd};

  `BFMP_CHECK_NEXT(a_one_request_in_flight, in_tvalid && in_tready, !in_tready)
  `BFMP_CHECK(a_used_within_buffer, out_tvalid, 32'(out_used) <= BUFFER_BYTES)
  `BFMP_CHECK(a_bad_width_reads_zero, out_tvalid && out_bw, out_rv == '0)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import bfmp_pkg::*;

  localparam int unsigned BUF = BUFFER_BYTES_DEF;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             bad_read;
    logic             overflowed;
    logic             bad_width;
    logic [CNT_W-1:0] range_warnings;
    logic [LEN_W-1:0] used_bytes;
  } packer_result_t;

  typedef struct {
    cmd_t           cmd;
    logic [31:0]    value;
    logic [5:0]     width;
    logic           sg;
    bit             fixed;
    packer_result_t golden;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [TUSER_W-1:0]    in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0]    out_tuser;
  logic                  cfg_wr_en;
  logic [LEN_W-1:0]      cfg_wr_data;

  bit_field_message_packer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the packer state
  logic [7:0]  image_bytes [0:BUF-1];
  bit          image_written [0:BUF-1];
  int unsigned cap_setting;
  int unsigned fill_len;
  int unsigned fetch_pos;
  int unsigned bit_ofs;
  int unsigned warn_total;
  bit          ovf_sticky;
  bit          bad_rd_sticky;

  packer_result_t pending_results [$];
  step_t          directed_steps [$];
  int unsigned    sent_count;
  int unsigned    fail_count;
  bit             no_idle;

  function automatic packer_result_t predict_packer_result(cmd_t cmd, logic [31:0] val,
                                                           logic [5:0] w, logic sg);
    packer_result_t r;
    int unsigned    cap, rem, take, idx, got, acc, bits;
    longint         v, half;
    bit             oor, failed;
    r = '0;
    case (cmd)
      CMD_BEGIN_WR: begin
        ovf_sticky = 1'b0;
        fill_len   = 0;
        bit_ofs    = 0;
      end
      CMD_WRITE: begin
        cap = (cap_setting < BUF) ? cap_setting : BUF;
        // capacity is checked before the width
        if (fill_len + HEADROOM_BYTES > cap) begin
          ovf_sticky = 1'b1;
        end else if (w == 0 || w > MAX_FIELD_BITS || (sg && w > 31)) begin
          r.bad_width = 1'b1;
        end else begin
          v = longint'($signed(val));
          if (w < 32) begin
            if (sg) begin
              half = longint'(1) << (w - 1);
              oor  = (v > half - 1) || (v < -half);
            end else begin
              oor = (v < 0) || (v > (longint'(1) << w) - 1);
            end
            if (oor) warn_total = warn_total + 1;
          end
          rem  = w;
          bits = val;
          while (rem != 0) begin
            if (bit_ofs == 0) begin
              image_bytes[fill_len % BUF]   = 8'h00;
              image_written[fill_len % BUF] = 1'b1;
              fill_len = fill_len + 1;
            end
            take = 8 - bit_ofs;
            if (take > rem) take = rem;
            idx = (fill_len + BUF - 1) % BUF;
            image_bytes[idx] = image_bytes[idx] |
                               8'((bits & ((32'd1 << take) - 1)) << bit_ofs);
            bits    = bits >> take;
            rem     = rem - take;
            bit_ofs = (bit_ofs + take) & 7;
          end
        end
      end
      CMD_BEGIN_RD: begin
        bit_ofs       = 0;
        fetch_pos     = 0;
        bad_rd_sticky = 1'b0;
      end
      default: begin
        if (w > MAX_FIELD_BITS) begin
          r.bad_width = 1'b1;
        end else begin
          acc    = 0;
          got    = 0;
          failed = 1'b0;
          while (got < w && !failed) begin
            if (bit_ofs == 0) begin
              if (fetch_pos + 1 > fill_len) begin
                bad_rd_sticky = 1'b1;
                failed        = 1'b1;
              end else begin
                fetch_pos = fetch_pos + 1;
              end
            end
            if (!failed) begin
              take = 8 - bit_ofs;
              if (take > w - got) take = w - got;
              idx = (fetch_pos + BUF - 1) % BUF;
              acc = acc | (((int'(image_bytes[idx]) >> bit_ofs) &
                            ((32'd1 << take) - 1)) << got);
              bit_ofs = (bit_ofs + take) & 7;
              got     = got + take;
            end
          end
          if (failed) begin
            r.read_value = '1;
          end else begin
            if (sg && w != 0 && w < 32 && acc[w-1]) acc = acc | ~((32'd1 << w) - 1);
            r.read_value = acc;
          end
        end
      end
    endcase
    r.bad_read       = bad_rd_sticky;
    r.overflowed     = ovf_sticky;
    r.range_warnings = warn_total;
    r.used_bytes     = fill_len[LEN_W-1:0];
    return r;
  endfunction

  task automatic send_request(cmd_t cmd, logic [31:0] val, logic [5:0] w, logic sg,
                              bit fixed, packer_result_t golden);
    int unsigned    gap;
    packer_result_t pred;
    // a read that would start in the never-written top byte becomes a begin-read
    if (cmd == CMD_READ && w != 0 && w <= MAX_FIELD_BITS && bit_ofs != 0 &&
        fetch_pos == 0 && !image_written[BUF-1])
      cmd = CMD_BEGIN_RD;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, w, val};
    in_tuser  <= {sg, cmd};
    do @(posedge clk); while (!in_tready);
    pred = predict_packer_result(cmd, val, w, sg);
    pending_results.push_back(fixed ? golden : pred);
    sent_count = sent_count + 1;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned cap);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap[LEN_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_setting = cap & 32'h1FFF;
  endtask

  task automatic add_step(cmd_t cmd, logic [31:0] val, logic [5:0] w, logic sg,
                          bit fixed, packer_result_t golden);
    step_t s;
    s.cmd    = cmd;
    s.value  = val;
    s.width  = w;
    s.sg     = sg;
    s.fixed  = fixed;
    s.golden = golden;
    directed_steps.push_back(s);
  endtask

  // mostly well-formed messages: begin write, fields, begin read, read back
  task automatic run_message_phase(int unsigned n_items);
    int unsigned start, nf, k;
    logic [5:0]  fw [$];
    logic        fsg [$];
    logic [5:0]  w;
    logic        sg;
    longint      lo, hi, v;
    start = sent_count;
    while (sent_count - start < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        no_idle = 1'b0;
        send_request(cmd_t'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        no_idle = ($urandom_range(0, 4) == 0);
        fw.delete();
        fsg.delete();
        send_request(CMD_BEGIN_WR, $urandom, 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
        nf = $urandom_range(1, 8);
        for (k = 0; k < nf; k++) begin
          w  = 6'($urandom_range(1, 32));
          sg = (w < 32 || $urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
          if (sg) begin
            lo = -(longint'(1) << (w - 1));
            hi = (longint'(1) << (w - 1)) - 1;
          end else begin
            lo = 0;
            hi = (longint'(1) << w) - 1;
          end
          case ($urandom_range(0, 4))
            0:       v = longint'($urandom);
            1:       v = lo;
            2:       v = hi;
            3:       v = $urandom_range(0, 1) ? hi + 1 : lo - 1;
            default: v = lo + longint'($urandom) % (hi - lo + 1);
          endcase
          fw.push_back(w);
          fsg.push_back(sg);
          send_request(CMD_WRITE, v[31:0], w, sg, 1'b0, '0);
        end
        // sometimes keep reading from the writer's bit position
        if ($urandom_range(0, 5) != 0)
          send_request(CMD_BEGIN_RD, $urandom, 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
        for (k = 0; k < nf; k++) begin
          w = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 32)) : fw[k];
          send_request(CMD_READ, $urandom, w, fsg[k], 1'b0, '0);
        end
        nf = $urandom_range(0, 2);
        for (k = 0; k < nf; k++)
          send_request(CMD_READ, $urandom, 6'($urandom_range(0, 32)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] act);
    if (act !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, act);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin : result_check
    packer_result_t want;
    packer_result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tdata[31:0], out_tuser[0], out_tuser[1], out_tuser[2],
              out_tdata[63:32], out_tdata[76:64]};
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count = fail_count + 1;
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, seen.read_value);
        check_field("bad_read", 32'(want.bad_read), 32'(seen.bad_read));
        check_field("overflowed", 32'(want.overflowed), 32'(seen.overflowed));
        check_field("bad_width", 32'(want.bad_width), 32'(seen.bad_width));
        check_field("range_warnings", want.range_warnings, seen.range_warnings);
        check_field("used_bytes", 32'(want.used_bytes), 32'(seen.used_bytes));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  initial begin
    #3_000_000;
    $display("bit_field_message_packer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned caps [7];
    int unsigned i;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    for (i = 0; i < BUF; i++) begin
      image_bytes[i]   = 8'h00;
      image_written[i] = 1'b0;
    end
    cap_setting   = CAP_RESET;
    fill_len      = 0;
    fetch_pos     = 0;
    bit_ofs       = 0;
    warn_total    = 0;
    ovf_sticky    = 1'b0;
    bad_rd_sticky = 1'b0;
    sent_count    = 0;
    fail_count    = 0;
    no_idle       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // read of an empty store, illegal widths, field extremes
    add_step(CMD_READ, 32'h0, 6'd8, 1'b0, 1'b1, {32'hFFFF_FFFF, 3'b100, 32'd0, 13'd0});
    add_step(CMD_BEGIN_RD, 32'h0, 6'd0, 1'b0, 1'b1, '0);
    add_step(CMD_WRITE, 32'h5, 6'd0, 1'b0, 1'b1, {32'd0, 3'b001, 32'd0, 13'd0});
    add_step(CMD_WRITE, 32'h5, 6'd33, 1'b0, 1'b1, {32'd0, 3'b001, 32'd0, 13'd0});
    add_step(CMD_WRITE, 32'h0, 6'd32, 1'b1, 1'b1, {32'd0, 3'b001, 32'd0, 13'd0});
    add_step(CMD_WRITE, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, {32'd0, 3'b001, 32'd0, 13'd0});
    add_step(CMD_READ, 32'h0, 6'd33, 1'b0, 1'b1, {32'd0, 3'b001, 32'd0, 13'd0});
    add_step(CMD_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b1, {32'd0, 3'b000, 32'd0, 13'd4});
    add_step(CMD_WRITE, 32'h8000_0000, 6'd31, 1'b1, 1'b1, {32'd0, 3'b000, 32'd1, 13'd8});
    add_step(CMD_WRITE, 32'h1, 6'd1, 1'b0, 1'b1, {32'd0, 3'b000, 32'd1, 13'd8});
    add_step(CMD_WRITE, 32'h2, 6'd1, 1'b0, 1'b0, '0);
    add_step(CMD_WRITE, 32'hFFFF_FFFF, 6'd1, 1'b1, 1'b0, '0);
    add_step(CMD_WRITE, 32'h7FFF_FFFF, 6'd31, 1'b1, 1'b0, '0);
    add_step(CMD_WRITE, 32'hFFFF_FFFF, 6'd8, 1'b0, 1'b0, '0);
    add_step(CMD_BEGIN_RD, 32'h0, 6'd0, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd32, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd31, 1'b1, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd0, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd32, 1'b1, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd32, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd4, 1'b0, 1'b0, '0);
    add_step(CMD_BEGIN_WR, 32'h0, 6'd0, 1'b0, 1'b0, '0);
    add_step(CMD_WRITE, 32'hA5, 6'd8, 1'b0, 1'b0, '0);
    add_step(CMD_WRITE, 32'h13, 6'd5, 1'b0, 1'b0, '0);
    add_step(CMD_BEGIN_RD, 32'h0, 6'd0, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd3, 1'b0, 1'b0, '0);
    // writer picks up at the bit position the reader left
    add_step(CMD_WRITE, 32'h1FF, 6'd9, 1'b0, 1'b0, '0);
    add_step(CMD_READ, 32'h0, 6'd16, 1'b1, 1'b0, '0);
    foreach (directed_steps[i])
      send_request(directed_steps[i].cmd, directed_steps[i].value, directed_steps[i].width,
                   directed_steps[i].sg, directed_steps[i].fixed, directed_steps[i].golden);

    caps[0] = 4;
    caps[1] = 0;
    caps[2] = 8191;
    caps[3] = 11;
    caps[4] = 37;
    caps[5] = 4096;
    caps[6] = $urandom_range(4, 64);
    for (i = 0; i < 7; i++) begin
      set_capacity(caps[i]);
      run_message_phase(85);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("bit_field_message_packer regression: pass");
    end else begin
      $display("bit_field_message_packer regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/bfmp_pkg.sv
src/bfmp_ram.sv
src/bfmp_ctrl.sv
src/bfmp_dp.sv
src/bit_field_message_packer.sv
tb/sv/tb.sv
